// ===== rtl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants for the contour start scanner
// Beat payloads, configuration bundle, register indexes and status codes.
// ----------------------------------------------------------------------------
package csb_pkg;

    // Pixel classes
    localparam logic [1:0] CLS_UNDER   = 2'd0;
    localparam logic [1:0] CLS_OBJECT  = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_SEARCHING = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FINISHED  = 3'd3;
    localparam logic [2:0] ST_BAD_START = 3'd4;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_SCAN_VERTICAL = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [2:0] REG_START_X       = 3'd4;
    localparam logic [2:0] REG_START_Y       = 3'd5;

    typedef struct packed {
        logic [1:0] pixel_class;
        logic       pixel_marked;
        logic [1:0] neighbor_a_class;
        logic [1:0] neighbor_b_class;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  scan_status;
        logic [11:0] found_x;
        logic [11:0] found_y;
    } t_out_beat;

    typedef struct packed {
        logic        scan_vertical;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [11:0] line_stride;
        logic [11:0] start_x;
        logic [11:0] start_y;
    } t_cfg;

endpackage

// ===== rtl/csb_regs.sv =====
// ----------------------------------------------------------------------------
// csb_regs: configuration register bank
// APB-style slave holding the scan direction, image size, stride and start.
// ----------------------------------------------------------------------------
module csb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output csb_pkg::t_cfg      o_cfg
);
    import csb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_vertical <= 1'b0;
            r_cfg.image_width   <= 13'd640;
            r_cfg.image_height  <= 13'd480;
            r_cfg.line_stride   <= 12'd1;
            r_cfg.start_x       <= 12'd0;
            r_cfg.start_y       <= 12'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCAN_VERTICAL: r_cfg.scan_vertical <= pwdata[0];
                REG_IMAGE_WIDTH:   r_cfg.image_width   <= pwdata[12:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height  <= pwdata[12:0];
                REG_LINE_STRIDE:   r_cfg.line_stride   <= pwdata[11:0];
                REG_START_X:       r_cfg.start_x       <= pwdata[11:0];
                REG_START_Y:       r_cfg.start_y       <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCAN_VERTICAL: prdata = {31'd0, r_cfg.scan_vertical};
            REG_IMAGE_WIDTH:   prdata = {19'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {19'd0, r_cfg.image_height};
            REG_LINE_STRIDE:   prdata = {20'd0, r_cfg.line_stride};
            REG_START_X:       prdata = {20'd0, r_cfg.start_x};
            REG_START_Y:       prdata = {20'd0, r_cfg.start_y};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/csb_core.sv =====
// ----------------------------------------------------------------------------
// csb_core: scan position tracking and object start detection
// Input register, one pass of compare logic, result register.
// ----------------------------------------------------------------------------
module csb_core #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csb_pkg::t_cfg         i_cfg,
    input  logic                  i_in_valid,
    input  csb_pkg::t_in_beat     i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output csb_pkg::t_out_beat    o_out_data,
    input  logic                  i_out_stall
);
    import csb_pkg::*;

    // Dimensions are 13 bits wide, so a limit above 8191 never clamps.
    localparam int unsigned CLAMP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;

    typedef enum logic [3:0] {
        PH_FIRST = 4'b0001,
        PH_LINE  = 4'b0010,
        PH_IN    = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_prev_class, n_prev_class;
    logic        r_prev_nu, n_prev_nu;
    logic [11:0] r_along, n_along;
    logic [11:0] r_line, n_line;
    t_out_beat   n_out;

    logic        advance;
    logic [12:0] eff_w, eff_h, along_len, line_len;
    logic [11:0] stride;
    logic        bad_start;
    logic [11:0] cur_along, cur_line, rep_along;
    logic [1:0]  cur;
    logic        nu;
    logic        found;
    logic [12:0] next_along, next_line;
    logic [2:0]  status;

    assign advance    = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign eff_w = (i_cfg.image_width  > 13'(CLAMP)) ? 13'(CLAMP) : i_cfg.image_width;
    assign eff_h = (i_cfg.image_height > 13'(CLAMP)) ? 13'(CLAMP) : i_cfg.image_height;
    assign along_len = i_cfg.scan_vertical ? eff_h : eff_w;
    assign line_len  = i_cfg.scan_vertical ? eff_w : eff_h;
    assign stride    = (i_cfg.line_stride == 12'd0) ? 12'd1 : i_cfg.line_stride;

    assign bad_start = (eff_w < 13'd2) || (eff_h < 13'd2)
                     || ({1'b0, i_cfg.start_x} >= eff_w)
                     || ({1'b0, i_cfg.start_y} >= eff_h);

    // The start point is latched from the registers on the first pixel.
    assign cur_along = (r_phase == PH_FIRST)
                     ? (i_cfg.scan_vertical ? i_cfg.start_y : i_cfg.start_x) : r_along;
    assign cur_line  = (r_phase == PH_FIRST)
                     ? (i_cfg.scan_vertical ? i_cfg.start_x : i_cfg.start_y) : r_line;

    assign cur = (r_in.pixel_marked || r_in.pixel_class == 2'd3)
               ? CLS_UNKNOWN : r_in.pixel_class;
    assign nu  = (r_in.neighbor_a_class == CLS_UNDER) || (r_in.neighbor_b_class == CLS_UNDER);

    assign next_along = {1'b0, cur_along} + 13'd1;
    assign next_line  = {1'b0, cur_line} + {1'b0, stride};

    always_comb begin
        found     = 1'b0;
        rep_along = cur_along;
        if (r_phase == PH_IN && r_prev_class != cur) begin
            if (cur == CLS_OBJECT && (r_prev_class == CLS_UNDER
                    || (r_prev_class == CLS_UNKNOWN && nu))) begin
                found = 1'b1;
            end else if (r_prev_class == CLS_OBJECT && (cur == CLS_UNDER
                    || (cur == CLS_UNKNOWN && r_prev_nu))) begin
                // Leaving an object: the previous pixel is the start point.
                found     = 1'b1;
                rep_along = cur_along - 12'd1;
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_prev_class = r_prev_class;
        n_prev_nu    = r_prev_nu;
        n_along      = r_along;
        n_line       = r_line;
        status       = ST_SEARCHING;
        if (r_phase == PH_DONE) begin
            status = ST_FINISHED;
        end else if (r_phase == PH_FIRST && bad_start) begin
            status  = ST_BAD_START;
            n_phase = PH_DONE;
        end else if (found) begin
            status  = ST_FOUND;
            n_phase = PH_DONE;
        end else begin
            n_prev_class = cur;
            n_prev_nu    = nu;
            if (next_along >= along_len) begin
                if (next_line >= line_len) begin
                    status  = ST_NOT_FOUND;
                    n_phase = PH_DONE;
                end else begin
                    n_along = 12'd0;
                    n_line  = next_line[11:0];
                    n_phase = PH_LINE;
                end
            end else begin
                n_along = next_along[11:0];
                n_line  = cur_line;
                n_phase = PH_IN;
            end
        end
        n_out.scan_status = status;
        n_out.found_x = (status == ST_FOUND)
                      ? (i_cfg.scan_vertical ? cur_line : rep_along) : 12'd0;
        n_out.found_y = (status == ST_FOUND)
                      ? (i_cfg.scan_vertical ? rep_along : cur_line) : 12'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_FIRST;
            r_prev_class <= CLS_UNDER;
            r_prev_nu    <= 1'b0;
            r_along      <= 12'd0;
            r_line       <= 12'd0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_prev_class <= n_prev_class;
                r_prev_nu    <= n_prev_nu;
                r_along      <= n_along;
                r_line       <= n_line;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_gives_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_phase == PH_DONE) |=> (r_out.scan_status == ST_FINISHED))
        else $error("finished scan produced a status other than finished");

    a_coords_only_on_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.scan_status != ST_FOUND)
            |-> (r_out.found_x == 12'd0 && r_out.found_y == 12'd0))
        else $error("coordinates reported without a find");

    a_in_line_not_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IN) |-> (r_along != 12'd0))
        else $error("inside a line at along position zero");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("held input beat lost or overwritten");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance) |=> ($stable(r_phase) && $stable(r_along) && $stable(r_line)))
        else $error("scan state moved without an item");
`endif

endmodule

// ===== rtl/contour_start_scanner.sv =====
// ----------------------------------------------------------------------------
// contour_start_scanner: raster scan search for the first object start
// Pixels arrive in scan order on the input channel; every pixel gives one
// result beat. The first line begins at the start point, later lines begin at
// their first pixel and lie line_stride lines apart. The result reports
// searching, found (with the coordinates), not found, finished or bad start.
// Configuration is to be written through the APB-style port by the user while
// the block idles; the block itself does not enforce this. Each accepted beat
// passes through the input register and then the result register; one beat
// is taken every cycle while the receiver does not stall, set by the single
// pass of compare logic between the two registers. When the receiver stalls
// the result register holds, the input register fills, and then the input
// side is stalled. Reset empties both registers, restores the register
// defaults and arms the scan to latch the start point on the next pixel.
// After a found, not found or bad start result every pixel answers finished.
module contour_start_scanner #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    input  csb_pkg::t_in_beat     i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output csb_pkg::t_out_beat    o_out_data,
    input  logic                  i_out_stall
);
    import csb_pkg::*;

    t_cfg cfg;

    csb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    csb_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
